### rtl/core/hex_key_text_obfuscation_codec_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hex key text codec
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef HEX_KEY_TEXT_OBFUSCATION_CODEC_MACROS_SVH
`define HEX_KEY_TEXT_OBFUSCATION_CODEC_MACROS_SVH

`ifndef SYNTHESIS

`define HKC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hkc assertion failed");

`define HKC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hkc assertion failed");

`else

`define HKC_ASSERT_SAME(label, clk, rst, ante, cons)

`define HKC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/core/hkc_pkg.sv
// ----------------------------------------------------------------------------
// hkc_pkg
// Shared types, constants and character helpers of the hex key text codec.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hkc_pkg;

  localparam int MAX_CHARS   = 1024;
  localparam int COUNT_W     = 13;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd126;

  typedef enum logic {
    MODE_ENCRYPT = 1'b0,
    MODE_DECRYPT = 1'b1
  } mode_t;

  // One unit of work for the back end: one or four result characters.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic            quad;
    logic            bad;
    logic            string_end;
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) r = 8'd48 + {4'b0, d};
    else           r = 8'd65 - 8'd10 + {4'b0, d};
    return r;
  endfunction

  // Bit 4 set marks an invalid digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'd48 && c <= 8'd57)       r = 5'(c - 8'd48);
    else if (c >= 8'd65 && c <= 8'd70)  r = 5'(c - 8'd65 + 8'd10);
    else if (c >= 8'd97 && c <= 8'd102) r = 5'(c - 8'd97 + 8'd10);
    else                                r = 5'd16;
    return r;
  endfunction

endpackage

### rtl/core/hkc_ifs.sv
// ----------------------------------------------------------------------------
// hkc channel interfaces
// Valid/ready channels for text input, results and the mode register write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hkc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic [3:0] key;
  logic       last;
  modport source (output valid, symbol, key, last, input ready);
  modport sink   (input valid, symbol, key, last, output ready);
endinterface

interface hkc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_end;
  logic       bad_digit;
  logic       string_end;
  modport source (output valid, out_char, run_end, bad_digit, string_end, input ready);
  modport sink   (input valid, out_char, run_end, bad_digit, string_end, output ready);
endinterface

interface hkc_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### rtl/core/hkc_front.sv
// ----------------------------------------------------------------------------
// hkc_front
// Accepts input bytes, keeps the per-string state and builds result jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hkc_front #(
  parameter int MaxChars = hkc_pkg::MAX_CHARS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  hkc_pkg::mode_t       mode,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           symbol,
  input  logic [3:0]           key,
  input  logic                 last,
  output logic                 job_valid,
  output hkc_pkg::job_t        job,
  input  logic                 job_ready
);

  localparam logic [hkc_pkg::COUNT_W-1:0] Limit = hkc_pkg::COUNT_W'(MaxChars - 16);

  logic                         phase;
  logic [15:0]                  digit_buffer;
  logic [1:0]                   digit_count;
  logic [3:0]                   bad_mask;
  logic [hkc_pkg::COUNT_W-1:0]  emitted_count;
  logic                         stopped;

  logic        accept;
  logic        printable;
  logic        enc_try, enc_emit, enc_stop;
  logic [11:0] value;
  logic [7:0]  d0, d1, d2, kd;

  logic [4:0]  dv;
  logic [15:0] buf_new, buf_al;
  logic [3:0]  mask_new, mask_al;
  logic [2:0]  cnt;
  logic        fire;
  logic [3:0]  kv;
  logic [7:0]  val, c8, k8, dec_byte;
  logic        kbad, vbad;

  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;

  // Encrypt path: value = byte + 1 + key*240, with key*240 as (key<<8) - (key<<4).
  assign printable = (symbol >= hkc_pkg::PRINT_LO) && (symbol <= hkc_pkg::PRINT_HI);
  assign enc_try   = (mode == hkc_pkg::MODE_ENCRYPT) && printable && !stopped;
  assign enc_stop  = enc_try && (emitted_count > Limit);
  assign enc_emit  = enc_try && !(emitted_count > Limit);
  assign value     = {4'b0, symbol} + 12'd1 + {key, 8'b0} - {4'b0, key, 4'b0};
  assign d0        = hkc_pkg::hex_char(value[11:8]);
  assign d1        = hkc_pkg::hex_char(value[7:4]);
  assign d2        = hkc_pkg::hex_char(value[3:0]);
  assign kd        = hkc_pkg::hex_char(key);

  // Decrypt path: shift the digit in, decode once the group is complete or a short final group ends the string.
  assign dv       = hkc_pkg::hex_value(symbol);
  assign buf_new  = {digit_buffer[11:0], dv[3:0]};
  assign mask_new = {bad_mask[2:0], dv[4]};
  assign cnt      = {1'b0, digit_count} + 3'd1;
  assign fire     = (cnt == 3'd4) || (last && cnt >= 3'd2);

  // Left-align a short final group; absent digits count as missing.
  always_comb begin
    case (cnt)
      3'd2: begin
        buf_al  = {buf_new[7:0], 8'h00};
        mask_al = {mask_new[1:0], 2'b11};
      end
      3'd3: begin
        buf_al  = {buf_new[11:0], 4'h0};
        mask_al = {mask_new[2:0], 1'b1};
      end
      default: begin
        buf_al  = buf_new;
        mask_al = mask_new;
      end
    endcase
  end

  always_comb begin
    if (phase) begin
      kv   = buf_al[15:12];
      kbad = mask_al[3];
      val  = buf_al[7:0];
      vbad = |mask_al[2:0];
    end else begin
      kv   = buf_al[3:0];
      kbad = mask_al[0];
      val  = buf_al[11:4];
      vbad = |mask_al[3:1];
    end
  end

  // Mod 256, -240*k equals 16*k; a missing part stands for all ones.
  assign c8       = vbad ? 8'hFF : val;
  assign k8       = kbad ? 8'hFF : {4'b0, kv};
  assign dec_byte = c8 - 8'd1 + {k8[3:0], 4'b0};

  always_comb begin
    job            = '0;
    job.string_end = last;
    if (mode == hkc_pkg::MODE_ENCRYPT) begin
      job.quad  = 1'b1;
      job.chars = phase ? {d2, d1, d0, kd} : {kd, d2, d1, d0};
    end else begin
      job.chars = {24'b0, dec_byte};
      job.bad   = |mask_al;
    end
  end

  assign job_valid = in_valid &&
                     (enc_emit || ((mode == hkc_pkg::MODE_DECRYPT) && fire));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= 1'b0;
      digit_buffer  <= '0;
      digit_count   <= '0;
      bad_mask      <= '0;
      emitted_count <= '0;
      stopped       <= 1'b0;
    end else if (accept) begin
      if (last) begin
        phase         <= 1'b0;
        digit_buffer  <= '0;
        digit_count   <= '0;
        bad_mask      <= '0;
        emitted_count <= '0;
        stopped       <= 1'b0;
      end else if (mode == hkc_pkg::MODE_ENCRYPT) begin
        if (enc_emit) begin
          phase         <= ~phase;
          emitted_count <= emitted_count + hkc_pkg::COUNT_W'(4);
        end else if (enc_stop) begin
          stopped <= 1'b1;
        end
      end else if (fire) begin
        phase        <= ~phase;
        digit_buffer <= '0;
        digit_count  <= '0;
        bad_mask     <= '0;
      end else begin
        digit_buffer <= buf_new;
        digit_count  <= cnt[1:0];
        bad_mask     <= mask_new;
      end
    end
  end

endmodule

### rtl/core/hkc_queue.sv
// ----------------------------------------------------------------------------
// hkc_queue
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hkc_queue #(
  parameter int Depth = hkc_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hkc_pkg::job_t push_job,
  output logic          not_full,
  input  logic          pop,
  output logic          not_empty,
  output hkc_pkg::job_t pop_job
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  hkc_pkg::job_t entries [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] level;
  logic            do_push, do_pop;

  assign not_full  = (level != CntW'(Depth));
  assign not_empty = (level != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign pop_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      case ({do_push, do_pop})
        2'b10:   level <= level + CntW'(1);
        2'b01:   level <= level - CntW'(1);
        default: level <= level;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_job;
  end

endmodule

### rtl/core/hkc_back.sv
// ----------------------------------------------------------------------------
// hkc_back
// Takes jobs from the queue and emits their characters one per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hkc_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  input  hkc_pkg::job_t job,
  output logic          job_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_char,
  output logic          run_end,
  output logic          bad_digit,
  output logic          string_end
);

  hkc_pkg::job_t cur;
  logic          cur_valid;
  logic [1:0]    pos;
  logic          slot_free, emit, done;

  assign slot_free = !out_valid || out_ready;
  assign emit      = slot_free && cur_valid;
  assign done      = (pos == (cur.quad ? 2'd3 : 2'd0));
  assign job_pop   = job_valid && (!cur_valid || (emit && done));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      pos       <= '0;
    end else begin
      if (slot_free) out_valid <= cur_valid;
      if (emit) pos <= done ? 2'd0 : pos + 2'd1;
      if (job_pop)            cur_valid <= 1'b1;
      else if (emit && done)  cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) cur <= job;
    if (emit) begin
      out_char   <= cur.chars[pos];
      run_end    <= done;
      bad_digit  <= cur.bad;
      string_end <= cur.string_end;
    end
  end

endmodule

### rtl/core/hex_key_text_obfuscation_codec.sv
// ----------------------------------------------------------------------------
// hex_key_text_obfuscation_codec
// Top level of the hex key text codec: mode register, front, queue, back.
// ----------------------------------------------------------------------------
// In encrypt mode (mode 0) every printable byte with its key gives four
// uppercase hex characters, so an input transaction takes four result
// transactions, which the result register sends one per cycle while ready.
// Non-printable bytes and bytes past the per-string output limit give none.
// In decrypt mode (mode 1) the block takes one hex character per cycle while
// the queue has room and emits one decoded byte for each group of four
// (or for a short final group). Input is accepted whenever the two-entry
// job queue has room, so new bytes are classified while earlier characters
// are still being sent. Write mode only while the block is idle.
`timescale 1ns / 1ps
`include "hex_key_text_obfuscation_codec_macros.svh"

module hex_key_text_obfuscation_codec #(
  parameter int MaxChars   = hkc_pkg::MAX_CHARS,
  parameter int QueueDepth = hkc_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  hkc_in_if.sink     text,
  hkc_out_if.source  result,
  hkc_cfg_if.sink    cfg
);

  hkc_pkg::mode_t mode;
  logic           job_valid, job_ready, q_valid, q_pop;
  hkc_pkg::job_t  job, q_job;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= hkc_pkg::MODE_ENCRYPT;
    end else if (cfg.valid) begin
      mode <= hkc_pkg::mode_t'(cfg.data);
    end
  end

  hkc_front #(.MaxChars(MaxChars)) u_front (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .in_valid  (text.valid),
    .in_ready  (text.ready),
    .symbol    (text.symbol),
    .key       (text.key),
    .last      (text.last),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready)
  );

  hkc_queue #(.Depth(QueueDepth)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_valid),
    .push_job  (job),
    .not_full  (job_ready),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_job   (q_job)
  );

  hkc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (q_valid),
    .job        (q_job),
    .job_pop    (q_pop),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_char   (result.out_char),
    .run_end    (result.run_end),
    .bad_digit  (result.bad_digit),
    .string_end (result.string_end)
  );

  // Encrypted output is always an uppercase hex digit with no bad flag.
  `HKC_ASSERT_SAME(a_enc_hex_char, clk, rst, result.valid && (mode == hkc_pkg::MODE_ENCRYPT), (result.out_char >= 8'd48 && result.out_char <= 8'd57) || (result.out_char >= 8'd65 && result.out_char <= 8'd70))
  `HKC_ASSERT_SAME(a_enc_no_bad, clk, rst, result.valid && (mode == hkc_pkg::MODE_ENCRYPT), !result.bad_digit)
  // Hold a stalled result transaction steady until it is taken.
  `HKC_ASSERT_NEXT(a_result_hold, clk, rst, result.valid && !result.ready, result.valid && $stable(result.out_char))

endmodule
